// ----- sv/hashed_name_table_lookup_core_assert.svh -----
// Assertion macros for the hashed name table lookup core.
// Included by the controller and the datapath; depends on nothing else.
`ifndef HASHED_NAME_TABLE_LOOKUP_CORE_ASSERT_SVH
`define HASHED_NAME_TABLE_LOOKUP_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define HNTL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hntl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HNTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hntl assertion failed");

`else

`define HNTL_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HNTL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/hntl_pkg.sv -----
// Shared constants, types and control structs of the hashed name table lookup core.
// Depends on nothing; the interfaces, controller, datapath and top level import it.
`default_nettype none

package hntl_pkg;

   // Table geometry.
   localparam int unsigned TABLE_DEPTH = 512;
   localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned SPAN_W = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int unsigned INDEX_W = 9;
   localparam int unsigned KEY_W   = 21;
   localparam int unsigned STYLE_W = 10;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned HASH_W  = 32;
   localparam int unsigned ENTRY_W = KEY_W + STYLE_W;

   // FNV-1a constants.
   localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd1;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_NAME = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_SETTLE
   } state_type;

   typedef struct packed {
      logic hash_step;
      logic hash_last;
      logic mem_wr;
      logic rd_en;
      logic rd_sel_lo;
      logic step_update;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic span_gt1;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/hntl_req_if.sv -----
// Request channel interface: valid/ready handshake plus the input item fields.
// Depends on hntl_pkg for field widths.
`default_nettype none

interface hntl_req_if;
   import hntl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [INDEX_W-1:0]   entry_index;
   logic [KEY_W-1:0]     entry_key;
   logic [STYLE_W-1:0]   entry_style;
   logic [BYTE_W-1:0]    name_byte;
   logic                 last_byte;

   modport source (
      output valid, op, entry_index, entry_key, entry_style, name_byte, last_byte,
      input  ready
   );

   modport sink (
      input  valid, op, entry_index, entry_key, entry_style, name_byte, last_byte,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/hntl_rsp_if.sv -----
// Response channel interface: valid/ready handshake plus the result item fields.
// Depends on hntl_pkg for field widths.
`default_nettype none

interface hntl_rsp_if;
   import hntl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [STYLE_W-1:0]   style_index;
   logic [KEY_W-1:0]     name_hash;

   modport source (
      output valid, found, style_index, name_hash,
      input  ready
   );

   modport sink (
      input  valid, found, style_index, name_hash,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/hntl_datapath.sv -----
// Datapath: FNV-1a hash register, entry table memory, search bounds and result register.
// Depends on hntl_pkg and the assertion macro header.
`default_nettype none
`include "hashed_name_table_lookup_core_assert.svh"

module hntl_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  hntl_pkg::cmd_type            cmd,
   output hntl_pkg::status_type         sts,
   input  logic [hntl_pkg::INDEX_W-1:0] entry_index,
   input  logic [hntl_pkg::KEY_W-1:0]   entry_key,
   input  logic [hntl_pkg::STYLE_W-1:0] entry_style,
   input  logic [hntl_pkg::BYTE_W-1:0]  name_byte,
   input  logic                         csr_wr_en,
   input  logic [hntl_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [hntl_pkg::STYLE_W-1:0] rsp_style_index,
   output logic [hntl_pkg::KEY_W-1:0]   rsp_name_hash
);
   import hntl_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [HASH_W-1:0]  hash_mix;
   logic [HASH_W-1:0]  hash_next;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SPAN_W-1:0]  lo_ff, lo_in;
   logic [SPAN_W-1:0]  hi_ff, hi_in;
   logic [SPAN_W-1:0]  span;
   logic [SPAN_W-1:0]  mid;
   logic [SPAN_W-1:0]  hi_init;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]   rd_key;
   logic [STYLE_W-1:0] rd_style;
   logic               wr_in_range;
   logic               hit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff;
   logic [STYLE_W-1:0] style_ff;
   logic [KEY_W-1:0]   name_hash_ff;

   // Configuration register.
   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   // FNV-1a step: fold the byte in, then multiply by the prime modulo 2^32.
   assign hash_mix  = hash_ff ^ HASH_W'(name_byte);
   assign hash_next = hash_mix * HASH_PRIME;

   always_comb begin
      hash_in = hash_ff;
      if (cmd.hash_last) begin
         hash_in = FNV_BASIS;
      end else if (cmd.hash_step) begin
         hash_in = hash_next;
      end
   end

   assign key_in = cmd.hash_last ? hash_next[KEY_W-1:0] : key_ff;

   // Upper search bound: the entry count limited to one through the table depth.
   always_comb begin
      int unsigned n;
      n = 32'(count_ff);
      if (n < 1) begin
         n = 1;
      end
      if (n > TABLE_DEPTH) begin
         n = TABLE_DEPTH;
      end
      hi_init = SPAN_W'(n);
   end

   assign span = hi_ff - lo_ff;
   assign mid  = lo_ff + (span >> 1);
   assign rd_key   = rd_data_ff[ENTRY_W-1:STYLE_W];
   assign rd_style = rd_data_ff[STYLE_W-1:0];

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.hash_last) begin
         lo_in = '0;
         hi_in = hi_init;
      end else if (cmd.step_update) begin
         if (rd_key > key_ff) begin
            hi_in = mid;
         end else begin
            lo_in = mid;
         end
      end
   end

   // Table memory: one write port for loads, one registered read port for the search.
   assign wr_in_range = (32'(entry_index) < TABLE_DEPTH);
   assign rd_addr     = cmd.rd_sel_lo ? ADDR_W'(lo_ff) : ADDR_W'(mid);

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_in_range) begin
         table_mem[ADDR_W'(entry_index)] <= {entry_key, entry_style};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Result register.
   assign hit          = (rd_key == key_ff);
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         hash_ff      <= FNV_BASIS;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (cmd.rsp_load) begin
         found_ff     <= hit;
         style_ff     <= hit ? rd_style : '0;
         name_hash_ff <= key_ff;
      end
   end

   assign sts.span_gt1 = (span > SPAN_W'(1));
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_style_index = style_ff;
   assign rsp_name_hash   = name_hash_ff;

   // A search step always leaves a nonempty interval.
   `HNTL_ASSERT_NEXT(a_interval_nonempty, clock, reset, cmd.step_update, lo_ff < hi_ff)
   // The running hash restarts from the offset basis after every completed name.
   `HNTL_ASSERT_NEXT(a_hash_restart, clock, reset, cmd.hash_last, hash_ff == FNV_BASIS)
   // A miss never reports a style index.
   `HNTL_ASSERT_NOW(a_miss_style_zero, clock, reset, rsp_valid_ff && !found_ff,
      style_ff == '0)

endmodule

`default_nettype wire

// ----- sv/hntl_ctrl.sv -----
// Controller state machine: accepts items, sequences the binary search, loads the result.
// Depends on hntl_pkg and the assertion macro header.
`default_nettype none
`include "hashed_name_table_lookup_core_assert.svh"

module hntl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   input  logic                 req_last,
   output logic                 req_ready,
   input  hntl_pkg::status_type sts,
   output hntl_pkg::cmd_type    cmd
);
   import hntl_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_NAME && req_last) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = sts.span_gt1 ? ST_COMPARE : ST_SETTLE;
         end
         ST_COMPARE: begin
            state_in = ST_PROBE;
         end
         ST_SETTLE: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.hash_step = accept && req_op == OP_NAME;
            cmd.hash_last = accept && req_op == OP_NAME && req_last;
            cmd.mem_wr    = accept && req_op == OP_LOAD;
         end
         ST_PROBE: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel_lo = !sts.span_gt1;
         end
         ST_COMPARE: begin
            cmd.step_update = 1'b1;
         end
         ST_SETTLE: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A search starts only from an accepted final name byte.
   `HNTL_ASSERT_NOW(a_search_start, clock, reset,
      state_ff == ST_PROBE && $past(state_ff) == ST_IDLE,
      $past(req_valid && req_op == OP_NAME && req_last))
   // Every compare is followed by another probe.
   `HNTL_ASSERT_NEXT(a_compare_then_probe, clock, reset, state_ff == ST_COMPARE,
      state_ff == ST_PROBE)
   // Once the result is loaded the block returns to taking items.
   `HNTL_ASSERT_NEXT(a_settle_done, clock, reset, state_ff == ST_SETTLE && sts.rsp_free,
      state_ff == ST_IDLE)

endmodule

`default_nettype wire

// ----- sv/hashed_name_table_lookup_core.sv -----
// Top level of the hashed name table lookup core: ports, controller and datapath.
// Depends on hntl_pkg, hntl_req_if, hntl_rsp_if, hntl_ctrl and hntl_datapath.
`default_nettype none

// The core hashes names with 32-bit FNV-1a and looks the hash up in a sorted
// table of 512 entries. A transfer on the request channel with op = 0 writes one
// table entry (key and style index) into the slot given by entry_index; slots
// at or beyond the table depth are ignored. A transfer with op = 1 folds one
// name byte into the running hash. On the byte marked last, the hash is masked
// to 21 bits and a binary search runs over the first entry_count entries
// (entry_count of 0 is searched as 1). The search settles on the last entry
// whose key is not greater than the masked hash, and one response transfer
// reports found, the style index (0 on a miss) and the masked hash. The table
// lives in a single-port-read memory with a registered read, so each search
// probe is a read and then a compare, for at most ceil(log2(entry_count))
// probes and so at most 9, followed by a final read of the chosen entry. The
// request channel is held off while the search runs, and longer only when a
// finished search finds the previous response still waiting in the output
// register; it then stays held off until that response leaves. The result
// sits in an output register, so the next name or load is taken while a
// response still waits for the consumer. Load the table in ascending key order
// and write entry_count only while the core is idle; entries that were never
// written must not fall inside the searched range.

module hashed_name_table_lookup_core (
   input  logic                         clock,
   input  logic                         reset,
   hntl_req_if.sink                     req_chan,
   hntl_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [hntl_pkg::COUNT_W-1:0] csr_wr_data
);
   import hntl_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // The controller sees only the handshake and the two fields that steer it.
   hntl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the hash, the table, the search bounds and the result register.
   hntl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .entry_index     (req_chan.entry_index),
      .entry_key       (req_chan.entry_key),
      .entry_style     (req_chan.entry_style),
      .name_byte       (req_chan.name_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_found       (rsp_chan.found),
      .rsp_style_index (rsp_chan.style_index),
      .rsp_name_hash   (rsp_chan.name_hash)
   );

endmodule

`default_nettype wire
